// ===== rtl/mcs_pkg.sv =====
// Shared types and constants for the multinomial CDF sampler.
// Used by mcs_cell and multinomial_cdf_sampler; no dependencies.
package mcs_pkg;

    localparam int COUNT_W  = 9;   // class count, search bounds, result index
    localparam int INDEX_W  = 8;   // entry_index field
    localparam int WEIGHT_W = 32;  // cumulative weights
    localparam int FRAC_W   = 16;  // Q0.16 uniform fraction
    localparam int PROD_W   = WEIGHT_W + FRAC_W;

    localparam int MAX_CLASSES_DEF = 256;

    localparam logic [COUNT_W-1:0] CLASS_COUNT_RESET = COUNT_W'(256);

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Search window carried from cell to cell.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] lo;
        logic [COUNT_W-1:0] span;
    } search_t;

endpackage

// ===== rtl/mcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mcs_cell.sv =====
// One step of the upper-bound binary search: narrows the window with the
// probed weight and issues the probe address for the next cell.
// Depends on mcs_pkg.
module mcs_cell #(
    parameter int ADDR_W = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcs_pkg::search_t                  cur,
    input  logic [mcs_pkg::WEIGHT_W-1:0]      rd_data,
    input  logic [mcs_pkg::WEIGHT_W-1:0]      thr,
    output mcs_pkg::search_t                  nxt_q,
    output logic [ADDR_W-1:0]                 probe_addr
);

    import mcs_pkg::*;

    logic [COUNT_W-1:0] half;
    logic [COUNT_W-1:0] probe;
    search_t            win_next;
    logic               valid_reg;
    logic [COUNT_W-1:0] lo_reg;
    logic [COUNT_W-1:0] span_reg;

    always_comb
    begin
        half     = cur.span >> 1;
        probe    = cur.lo + half;
        win_next = cur;
        if (cur.span != '0)
        begin
            if (rd_data <= thr)
            begin
                win_next.lo   = probe + COUNT_W'(1);
                win_next.span = cur.span - half - COUNT_W'(1);
            end
            else
            begin
                win_next.span = half;
            end
        end
    end

    // only the active cell drives the shared read address
    assign probe_addr = cur.valid
                      ? ADDR_W'(win_next.lo + (win_next.span >> 1))
                      : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cur.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= win_next.lo;
        span_reg <= win_next.span;
    end

    assign nxt_q = '{valid: valid_reg, lo: lo_reg, span: span_reg};

endmodule

// ===== rtl/multinomial_cdf_sampler.sv =====
// Top level of the multinomial CDF sampler: cumulative table RAM, scaling
// stage, chain of search cells and output register.
// Depends on mcs_pkg, mcs_ram, mcs_cell.
//
//  channel  | signals                                            | dir
//  ---------+----------------------------------------------------+-----
//  config   | cfg_we, cfg_data (class_count)                     | in
//  request  | in_valid/in_ready, req_type, entry_index,          | in
//           | cumulative_value, uniform_fraction                 |
//  result   | out_valid/out_ready, sample_index                  | out
//
// A load request gives no result.
// A sample request reads the last entry, is scaled, passes through each search
// cell in turn and is then loaded into the output register.
// The single RAM read port is used once per cycle by the active stage.
// A waiting result in the output register does not block the next request;
// a second finished result waits in a holding register with in_ready low.
// Reset clears all control state; the table is undefined until written.
module multinomial_cdf_sampler #(
    parameter int MAX_CLASSES = mcs_pkg::MAX_CLASSES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mcs_pkg::COUNT_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [mcs_pkg::INDEX_W-1:0]     entry_index,
    input  logic [mcs_pkg::WEIGHT_W-1:0]    cumulative_value,
    input  logic [mcs_pkg::FRAC_W-1:0]      uniform_fraction,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mcs_pkg::COUNT_W-1:0]     sample_index
);

    import mcs_pkg::*;

    localparam int ADDR_W    = $clog2(MAX_CLASSES);
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int N_USE_MAX = (MAX_CLASSES < COUNT_MAX) ? MAX_CLASSES : COUNT_MAX;
    localparam int STEPS     = $clog2(N_USE_MAX + 1);

    logic [COUNT_W-1:0]  class_count_reg;
    logic [COUNT_W-1:0]  n_use;
    logic                accept;
    logic                accept_sample;
    logic                load_we;

    logic                busy_reg;
    logic                scale_valid_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [COUNT_W-1:0]  n_reg;
    logic [WEIGHT_W-1:0] thr_reg;
    logic [PROD_W-1:0]   product;
    logic                seed_valid_reg;
    logic [COUNT_W-1:0]  seed_span_reg;
    search_t             seed;

    logic [ADDR_W-1:0]   rd_addr;
    logic [WEIGHT_W-1:0] rd_data;

    search_t             cell_in   [STEPS];
    search_t             cell_q    [STEPS];
    logic [ADDR_W-1:0]   cell_addr [STEPS];
    logic [ADDR_W-1:0]   cells_addr;
    logic [STEPS-1:0]    cell_active;

    search_t             last;
    logic                pend_valid_reg;
    logic [COUNT_W-1:0]  pend_lo_reg;
    logic                move;
    logic [COUNT_W-1:0]  move_lo;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  sample_index_reg;

    // class count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= CLASS_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            class_count_reg <= cfg_data;
        end
    end

    assign n_use = (class_count_reg > MAX_CLASSES) ? COUNT_W'(MAX_CLASSES)
                                                   : class_count_reg;

    assign in_ready      = !busy_reg;
    assign accept        = in_valid && in_ready;
    assign accept_sample = accept && (req_type == REQ_SAMPLE);
    assign load_we       = accept && (req_type == REQ_LOAD) && (entry_index < MAX_CLASSES);

    mcs_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_CLASSES)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (ADDR_W'(entry_index)),
        .wdata (cumulative_value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // read address: last entry at accept, first probe while scaling, then cells
    always_comb
    begin
        cells_addr = '0;
        for (int k = 0; k < STEPS; k++)
        begin
            cells_addr = cells_addr | cell_addr[k];
        end
        if (accept_sample)
        begin
            rd_addr = ADDR_W'(n_use - COUNT_W'(1));
        end
        else if (scale_valid_reg)
        begin
            rd_addr = ADDR_W'(n_reg >> 1);
        end
        else
        begin
            rd_addr = cells_addr;
        end
    end

    assign product = frac_reg * rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
            seed_valid_reg  <= 1'b0;
        end
        else
        begin
            scale_valid_reg <= accept_sample;
            seed_valid_reg  <= scale_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_sample)
        begin
            frac_reg <= uniform_fraction;
            n_reg    <= n_use;
        end
        if (scale_valid_reg)
        begin
            thr_reg       <= product[PROD_W-1:FRAC_W];
            seed_span_reg <= n_reg;
        end
    end

    // search always starts from the bottom of the table
    assign seed = '{valid: seed_valid_reg, lo: '0, span: seed_span_reg};

    genvar g;
    generate
        for (g = 0; g < STEPS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign cell_in[g] = seed;
            end
            else
            begin : g_link
                assign cell_in[g] = cell_q[g-1];
            end
            mcs_cell #(
                .ADDR_W (ADDR_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cur        (cell_in[g]),
                .rd_data    (rd_data),
                .thr        (thr_reg),
                .nxt_q      (cell_q[g]),
                .probe_addr (cell_addr[g])
            );
            assign cell_active[g] = cell_q[g].valid;
        end
    endgenerate

    assign last    = cell_q[STEPS-1];
    assign move    = (last.valid || pend_valid_reg) && (!out_valid_reg || out_ready);
    assign move_lo = last.valid ? last.lo : pend_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept_sample)
            begin
                busy_reg <= 1'b1;
            end
            else if (move)
            begin
                busy_reg <= 1'b0;
            end

            if (last.valid && !move)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (last.valid)
        begin
            pend_lo_reg <= last.lo;
        end
        if (move)
        begin
            sample_index_reg <= move_lo;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_index = sample_index_reg;

    // no search stage is active while new requests are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(|cell_active) && !scale_valid_reg && !seed_valid_reg)
        else $error("search active while in_ready high");

    // a sample request sits in at most one place of the pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({scale_valid_reg, seed_valid_reg, cell_active, pend_valid_reg}))
        else $error("more than one sample in flight");

    // an accepted sample starts scaling and holds off further requests
    assert property (@(posedge clk) disable iff (!rst_n)
        accept_sample |=> scale_valid_reg && busy_reg)
        else $error("sample request not started");

endmodule
